// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the BMP blit block.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/bmpb_pkg.sv =====
// Shared types, constants and the reciprocal table of the BMP blit block.
// No dependencies; used by bmpb_unpack, bmpb_place and the top level.
package bmpb_pkg;

	localparam int FB_STRIDE   = 800;
	localparam int FB_ROWS     = 480;
	localparam int RECIP_SHIFT = 18;

	typedef enum logic [2:0] {
		REG_IMG_WIDTH  = 3'd0,
		REG_IMG_HEIGHT = 3'd1,
		REG_DEST_X     = 3'd2,
		REG_DEST_Y     = 3'd3,
		REG_SHRINK     = 3'd4
	} reg_idx_t;

	// Effective configuration: sizes forced to at least one, shrink within 1..16
	typedef struct packed {
		logic [9:0] width;
		logic [8:0] height;
		logic [4:0] shrink;
		logic [9:0] dest_x;
		logic [8:0] dest_y;
	} cfg_t;

	// One completed pixel on its way to placement
	typedef struct packed {
		logic [23:0] word;
		logic [8:0]  disp_row;
		logic [9:0]  out_col;
		logic        col_zero;
		logic        last_row;
		logic [9:0]  width_m1;
		logic [9:0]  dest_x;
		logic [8:0]  dest_y;
		logic [18:0] recip;
	} pix_t;

	// ceil(2^RECIP_SHIFT / s); exact quotient and zero-residue test for values below 1024
	function automatic logic [18:0] recip_of(input logic [4:0] s);
		logic [18:0] r;
		case (s)
			5'd1:    r = 19'd262144;
			5'd2:    r = 19'd131072;
			5'd3:    r = 19'd87382;
			5'd4:    r = 19'd65536;
			5'd5:    r = 19'd52429;
			5'd6:    r = 19'd43691;
			5'd7:    r = 19'd37450;
			5'd8:    r = 19'd32768;
			5'd9:    r = 19'd29128;
			5'd10:   r = 19'd26215;
			5'd11:   r = 19'd23832;
			5'd12:   r = 19'd21846;
			5'd13:   r = 19'd20165;
			5'd14:   r = 19'd18725;
			5'd15:   r = 19'd17477;
			5'd16:   r = 19'd16384;
			default: r = 19'd262144;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/bmpb_unpack.sv =====
// Byte unpacker: B,G,R assembly, pad skipping, row and column counters.
// Depends on bmpb_pkg; feeds completed pixels to bmpb_place.
module bmpb_unpack (
	input  logic            clk,
	input  logic            arst_n,
	input  bmpb_pkg::cfg_t  cfg,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,
	input  logic            s_tuser,
	input  logic            adv,
	output logic            pix_valid,
	output bmpb_pkg::pix_t  pix
);
	import bmpb_pkg::*;

	logic [1:0]  phase_q, cur_phase, nxt_phase;
	logic [15:0] held_q, cur_held, nxt_held;
	logic [9:0]  col_q, cur_col, nxt_col;
	logic [8:0]  row_q, cur_row, nxt_row;
	logic [1:0]  pad_q, cur_pad, nxt_pad;
	logic [3:0]  cres_q, cur_cres, nxt_cres;
	logic [9:0]  ocol_q, cur_ocol, nxt_ocol;
	logic        take, pixel;
	logic        v_s1;
	pix_t        pix_s1;

	assign s_tready = !v_s1 || adv;
	assign take     = s_tvalid && s_tready;

	assign cur_phase = s_tuser ? 2'd0  : phase_q;
	assign cur_held  = s_tuser ? 16'd0 : held_q;
	assign cur_col   = s_tuser ? 10'd0 : col_q;
	assign cur_row   = s_tuser ? 9'd0  : row_q;
	assign cur_pad   = s_tuser ? 2'd0  : pad_q;
	assign cur_cres  = s_tuser ? 4'd0  : cres_q;
	assign cur_ocol  = s_tuser ? 10'd0 : ocol_q;

	always_comb begin
		nxt_phase = cur_phase;
		nxt_held  = cur_held;
		nxt_col   = cur_col;
		nxt_row   = cur_row;
		nxt_pad   = cur_pad;
		nxt_cres  = cur_cres;
		nxt_ocol  = cur_ocol;
		pixel     = 1'b0;
		if (cur_row < cfg.height) begin
			if (cur_pad != 2'd0) begin
				nxt_pad = cur_pad - 2'd1;
			end else begin
				case (cur_phase)
					2'd0: begin
						nxt_held  = {cur_held[15:8], s_tdata};
						nxt_phase = 2'd1;
					end
					2'd1: begin
						nxt_held  = {s_tdata, cur_held[7:0]};
						nxt_phase = 2'd2;
					end
					default: begin
						pixel     = 1'b1;
						nxt_phase = 2'd0;
						if ({1'b0, cur_col} + 11'd1 >= {1'b0, cfg.width}) begin
							nxt_col  = 10'd0;
							nxt_cres = 4'd0;
							nxt_ocol = 10'd0;
							nxt_row  = cur_row + 9'd1;
							nxt_pad  = cfg.width[1:0];
						end else begin
							nxt_col = cur_col + 10'd1;
							if ({1'b0, cur_cres} + 5'd1 >= cfg.shrink) begin
								nxt_cres = 4'd0;
								nxt_ocol = cur_ocol + 10'd1;
							end else begin
								nxt_cres = cur_cres + 4'd1;
							end
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			held_q  <= 16'd0;
			col_q   <= 10'd0;
			row_q   <= 9'd0;
			pad_q   <= 2'd0;
			cres_q  <= 4'd0;
			ocol_q  <= 10'd0;
			v_s1    <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= nxt_phase;
				held_q  <= nxt_held;
				col_q   <= nxt_col;
				row_q   <= nxt_row;
				pad_q   <= nxt_pad;
				cres_q  <= nxt_cres;
				ocol_q  <= nxt_ocol;
			end
			if (s_tready) begin
				v_s1 <= take && pixel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && pixel) begin
			pix_s1.word     <= {s_tdata, cur_held};
			pix_s1.disp_row <= cfg.height - 9'd1 - cur_row;
			pix_s1.out_col  <= cur_ocol;
			pix_s1.col_zero <= (cur_cres == 4'd0);
			pix_s1.last_row <= (cur_row == cfg.height - 9'd1);
			pix_s1.width_m1 <= cfg.width - 10'd1;
			pix_s1.dest_x   <= cfg.dest_x;
			pix_s1.dest_y   <= cfg.dest_y;
			pix_s1.recip    <= recip_of(cfg.shrink);
		end
	end

	assign pix_valid = v_s1;
	assign pix       = pix_s1;

endmodule

// ===== hdl/bmpb_place.sv =====
// Pixel placement: decimation by reciprocal multiply, clipping, address and last-write flag.
// Depends on bmpb_pkg; takes pixels from bmpb_unpack and drives the result register.
module bmpb_place (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pix_valid,
	input  bmpb_pkg::pix_t  pix,
	output logic            adv,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [18:0]     fb_address,
	output logic [23:0]     pixel_word,
	output logic            image_done
);
	import bmpb_pkg::*;

	logic        en_out;
	logic        v_s2;
	logic [27:0] row_prod_s2;
	logic [28:0] wid_prod_s2;
	logic [23:0] word_s2;
	logic [9:0]  out_col_s2;
	logic        col_zero_s2, last_row_s2;
	logic [9:0]  dest_x_s2;
	logic [8:0]  dest_y_s2;
	logic [18:0] recip_s2;

	logic [8:0]  out_row;
	logic        row_zero;
	logic [9:0]  last_col, lim, last_kept;
	logic [9:0]  fb_row;
	logic [10:0] fb_col;
	logic        keep, done;
	logic [18:0] addr;

	logic        out_v_q;
	logic [18:0] addr_q;
	logic [23:0] word_q;
	logic        done_q;

	assign en_out = !out_v_q || m_tready;
	assign adv    = !v_s2 || en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pix_valid) begin
			row_prod_s2 <= pix.disp_row * pix.recip;
			wid_prod_s2 <= pix.width_m1 * pix.recip;
			word_s2     <= pix.word;
			out_col_s2  <= pix.out_col;
			col_zero_s2 <= pix.col_zero;
			last_row_s2 <= pix.last_row;
			dest_x_s2   <= pix.dest_x;
			dest_y_s2   <= pix.dest_y;
			recip_s2    <= pix.recip;
		end
	end

	always_comb begin
		out_row   = row_prod_s2[RECIP_SHIFT+8:RECIP_SHIFT];
		row_zero  = {1'b0, row_prod_s2[RECIP_SHIFT-1:0]} < recip_s2;
		last_col  = wid_prod_s2[RECIP_SHIFT+9:RECIP_SHIFT];
		lim       = 10'(FB_STRIDE - 1) - dest_x_s2;
		last_kept = (dest_x_s2 > 10'(FB_STRIDE - 1) || last_col < lim) ? last_col : lim;
		fb_row    = {1'b0, dest_y_s2} + {1'b0, out_row};
		fb_col    = {1'b0, dest_x_s2} + {1'b0, out_col_s2};
		keep      = col_zero_s2 && row_zero && fb_row < 10'(FB_ROWS)
		            && fb_col < 11'(FB_STRIDE);
		done      = last_row_s2 && out_col_s2 == last_kept;
		addr      = 19'(fb_row) * 19'(FB_STRIDE) + 19'(fb_col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= v_s2 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2 && keep) begin
			addr_q <= addr;
			word_q <= word_s2;
			done_q <= done;
		end
	end

	assign m_tvalid   = out_v_q;
	assign fb_address = addr_q;
	assign pixel_word = word_q;
	assign image_done = done_q;

endmodule

// ===== hdl/bmp_row_to_framebuffer_blit.sv =====
// Takes the pixel array of a 24-bit bottom-up BMP one byte per request, row padding included,
// and turns every kept pixel into one write of an 800 by 480 framebuffer. One byte is taken
// each cycle unless an output stall holds the pipeline; a pixel needs three bytes, though up
// to three writes can leave back to back once an output stall clears. A write passes the unpack
// register, the reciprocal-multiply register for the shrink division, then the result register.
// Pad bytes, dropped columns and rows, and pixels outside the buffer give no write. Set tuser on
// the first byte of each image to restart the counters; bytes after the last row are ignored
// until then. Configuration writes take effect from the next byte and are always accepted. No
// clearing pass after reset.
module bmp_row_to_framebuffer_blit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] image_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [18:0] fb_address, [42:19] pixel_word, [47:43] zero
	output logic        m_tlast    // image_done
);
	import bmpb_pkg::*;
	`include "assert_macros.svh"

	logic [9:0]  img_width_q;
	logic [8:0]  img_height_q;
	logic [9:0]  dest_x_q;
	logic [8:0]  dest_y_q;
	logic [4:0]  shrink_q;
	cfg_t        cfg;
	logic        pix_valid, adv;
	pix_t        pix;
	logic [18:0] fb_address;
	logic [23:0] pixel_word;
	logic        image_done;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q  <= 10'd800;
			img_height_q <= 9'd480;
			dest_x_q     <= 10'd0;
			dest_y_q     <= 9'd0;
			shrink_q     <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_IMG_WIDTH:  img_width_q  <= cfg_data;
				REG_IMG_HEIGHT: img_height_q <= cfg_data[8:0];
				REG_DEST_X:     dest_x_q     <= cfg_data;
				REG_DEST_Y:     dest_y_q     <= cfg_data[8:0];
				REG_SHRINK:     shrink_q     <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.width  = (img_width_q == 10'd0) ? 10'd1 : img_width_q;
		cfg.height = (img_height_q == 9'd0) ? 9'd1 : img_height_q;
		cfg.shrink = (shrink_q == 5'd0) ? 5'd1 : ((shrink_q > 5'd16) ? 5'd16 : shrink_q);
		cfg.dest_x = dest_x_q;
		cfg.dest_y = dest_y_q;
	end

	bmpb_unpack u_unpack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.adv       (adv),
		.pix_valid (pix_valid),
		.pix       (pix)
	);

	bmpb_place u_place (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix        (pix),
		.adv        (adv),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.fb_address (fb_address),
		.pixel_word (pixel_word),
		.image_done (image_done)
	);

	assign m_tdata = {5'd0, pixel_word, fb_address};
	assign m_tlast = image_done;

	`ASSERT_CLK(a_addr_in_buffer, m_tvalid |-> (m_tdata[18:0] < 19'(FB_STRIDE * FB_ROWS)), "write address outside framebuffer")
	`ASSERT_CLK(a_stall_from_output, !s_tready |-> m_tvalid, "input stalled with no result waiting")
	`ASSERT_NEVER(a_cfg_blocked, !cfg_ready, "configuration port refused a write")

endmodule

// ===== bench/bmp_row_to_framebuffer_blit_tb.sv =====
// Self-checking bench for bmp_row_to_framebuffer_blit: streams BMP pixel-array bytes and
// compares every framebuffer write with a cycle-free model of the blit kept in this file.
// Depends on bmpb_pkg for the register indexes and the framebuffer geometry.
module bmp_row_to_framebuffer_blit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bmpb_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 1250;
	localparam int CALM_AFTER   = 1000;
	localparam int BIG_BYTES    = 240;
	localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] REG_UNUSED_LAST  = 3'd7;

	typedef struct packed {
		logic [7:0] value;
		logic       start;
	} bmp_byte_t;

	typedef struct packed {
		logic [18:0] addr;
		logic [23:0] pixel;
		logic        done;
	} fb_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [9:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] data_byte
	logic        s_tuser = 1'b0; // [0] image_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // [18:0] fb_address, [42:19] pixel_word, [47:43] zero
	logic        m_tlast;        // image_done

	bmp_byte_t bmp_bytes[$];
	fb_write_t expected_writes[$];
	int        bytes_queued = 0;
	int        bytes_taken = 0;
	int        mismatches = 0;
	int        quiet_cycles = 0;
	int        send_gap = 0;
	int        take_gap = 0;
	bit        idle_on = 1'b1;
	logic      s_took = 1'b0;

	// register copies
	logic [9:0] img_w = 10'd800;
	logic [8:0] img_h = 9'd480;
	logic [9:0] dst_x = '0;
	logic [8:0] dst_y = '0;
	logic [4:0] shrink_by = 5'd1;

	// blit counters
	logic [1:0]  triple_pos = '0;
	logic [15:0] held_bg = '0;
	logic [9:0]  file_col = '0;
	logic [8:0]  file_row = '0;
	logic [1:0]  pad_left = '0;
	logic [3:0]  col_phase = '0;
	logic [9:0]  out_col = '0;

	bmp_row_to_framebuffer_blit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic bit predict_write(input logic [7:0] value, input logic start,
			output fb_write_t wr);
		int unsigned w, h, s, disp_row, fb_row, fb_col, last_col, room;
		logic [8:0] row_q;
		bit keep;
		wr = '0;
		w = (img_w == 0) ? 1 : img_w;
		h = (img_h == 0) ? 1 : img_h;
		s = (shrink_by == 0) ? 1 : ((shrink_by > 16) ? 16 : shrink_by);
		if (start) begin
			triple_pos = '0;
			held_bg = '0;
			file_col = '0;
			file_row = '0;
			pad_left = '0;
			col_phase = '0;
			out_col = '0;
		end
		if (file_row >= h)
			return 1'b0;
		if (pad_left != 0) begin
			pad_left = pad_left - 2'd1;
			return 1'b0;
		end
		if (triple_pos == 0) begin
			held_bg[7:0] = value;
			triple_pos = 2'd1;
			return 1'b0;
		end
		if (triple_pos == 1) begin
			held_bg[15:8] = value;
			triple_pos = 2'd2;
			return 1'b0;
		end
		triple_pos = '0;
		wr.pixel = {value, held_bg};
		disp_row = h - 1 - file_row;
		row_q = 9'(disp_row / s);
		fb_row = dst_y + row_q;
		fb_col = dst_x + out_col;
		keep = (disp_row % s == 0) && (col_phase == 0) && (fb_row < FB_ROWS)
			&& (fb_col < FB_STRIDE);
		if (keep && file_row == h - 1) begin
			last_col = (w - 1) / s;
			room = FB_STRIDE - 1 - dst_x;
			if (room < last_col)
				last_col = room;
			wr.done = (out_col == last_col);
		end
		if (file_col + 1 >= w) begin
			file_col = '0;
			col_phase = '0;
			out_col = '0;
			file_row = file_row + 9'd1;
			pad_left = 2'(w % 4);
		end else begin
			file_col = file_col + 10'd1;
			if (col_phase + 1 >= s) begin
				col_phase = '0;
				out_col = out_col + 10'd1;
			end else begin
				col_phase = col_phase + 4'd1;
			end
		end
		wr.addr = 19'(fb_row * FB_STRIDE + fb_col);
		return keep;
	endfunction

	function automatic void queue_byte(input logic [7:0] value, input logic start);
		bmp_byte_t b;
		b.value = value;
		b.start = start;
		bmp_bytes.push_back(b);
		bytes_queued++;
	endfunction

	function automatic int unsigned image_bytes(input int unsigned w, input int unsigned h);
		return h * (3 * w + w % 4);
	endfunction

	// first limit bytes of a well-formed image, start flag on the first
	function automatic int unsigned push_image(input int unsigned w, input int unsigned h,
			input int unsigned limit);
		int unsigned total;
		total = image_bytes(w, h);
		if (limit < total)
			total = limit;
		for (int unsigned k = 0; k < total; k++)
			queue_byte(8'($urandom), k == 0);
		return total;
	endfunction

	function automatic logic [9:0] reg_value(input logic [2:0] idx);
		logic [9:0] v;
		case (idx)
			REG_IMG_WIDTH:  v = ($urandom_range(0, 15) == 0) ? 10'd0 : 10'($urandom_range(1, 12));
			REG_IMG_HEIGHT: v = {1'($urandom),
				($urandom_range(0, 15) == 0) ? 9'd0 : 9'($urandom_range(1, 6))};
			REG_DEST_X: begin
				case ($urandom_range(0, 7))
					0, 1:    v = 10'd0;
					2, 3, 4: v = 10'($urandom_range(0, 799));
					5, 6:    v = 10'($urandom_range(785, 799));
					default: v = 10'($urandom_range(800, 1023));
				endcase
			end
			REG_DEST_Y: begin
				case ($urandom_range(0, 7))
					0, 1:    v = {1'($urandom), 9'd0};
					2, 3, 4: v = {1'($urandom), 9'($urandom_range(0, 479))};
					5, 6:    v = {1'($urandom), 9'($urandom_range(470, 479))};
					default: v = {1'($urandom), 9'($urandom_range(480, 511))};
				endcase
			end
			REG_SHRINK: v = {5'($urandom), ($urandom_range(0, 7) == 0) ?
				5'($urandom_range(0, 31)) : 5'($urandom_range(1, 4))};
			default: v = 10'($urandom);
		endcase
		return v;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [9:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic end_writes;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_quiet;
		while (bytes_taken != bytes_queued || expected_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin : feed
		bmp_byte_t cur;
		if (arst_n) begin
			if (!s_tvalid || s_took) begin
				if (send_gap != 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (bmp_bytes.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 6);
					s_tvalid <= 1'b0;
				end else begin
					cur = bmp_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur.value;
					s_tuser <= cur.start;
				end
			end
			if (take_gap != 0) begin
				take_gap--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				take_gap = $urandom_range(0, 6);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : observe
		fb_write_t want;
		if (arst_n) begin
			s_took <= s_tvalid && s_tready;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IMG_WIDTH:  img_w = cfg_data;
					REG_IMG_HEIGHT: img_h = cfg_data[8:0];
					REG_DEST_X:     dst_x = cfg_data;
					REG_DEST_Y:     dst_y = cfg_data[8:0];
					REG_SHRINK:     shrink_by = cfg_data[4:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				bytes_taken++;
				if (predict_write(s_tdata, s_tuser, want))
					expected_writes.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				if (expected_writes.size() == 0) begin
					mismatches++;
					$display("%0t: write with none expected, got address %0d pixel %h done %b",
						$time, m_tdata[18:0], m_tdata[42:19], m_tlast);
				end else begin
					want = expected_writes.pop_front();
					if (m_tdata[18:0] !== want.addr) begin
						mismatches++;
						$display("%0t: fb_address expected %0d got %0d", $time, want.addr,
							m_tdata[18:0]);
					end
					if (m_tdata[42:19] !== want.pixel) begin
						mismatches++;
						$display("%0t: pixel_word expected %h got %h", $time, want.pixel,
							m_tdata[42:19]);
					end
					if (m_tlast !== want.done) begin
						mismatches++;
						$display("%0t: image_done expected %b got %b", $time, want.done, m_tlast);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned random_items, w, h, n, k, shape, reps;
		logic [2:0] idx;
		bit wide_left, tall_left, big;
		random_items = 0;
		wide_left = 1'b1;
		tall_left = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default geometry: darkest and brightest pixel on the bottom framebuffer row
		queue_byte(8'h00, 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		wait_quiet();

		// one-pixel column at the far corner: first row falls off the buffer, zero shrink
		write_reg(REG_IMG_WIDTH, 10'd1);
		write_reg(REG_IMG_HEIGHT, 10'd2);
		write_reg(REG_DEST_X, 10'd799);
		write_reg(REG_DEST_Y, 10'd479);
		write_reg(REG_SHRINK, 10'd0);
		end_writes();
		queue_byte(8'hA5, 1'b1);
		queue_byte(8'h5A, 1'b0);
		queue_byte(8'hC3, 1'b0);
		queue_byte(8'h7E, 1'b0);
		queue_byte(8'h0F, 1'b0);
		queue_byte(8'hF0, 1'b0);
		queue_byte(8'h3C, 1'b0);
		queue_byte(8'h81, 1'b0);
		queue_byte(8'h99, 1'b0);
		wait_quiet();

		// zero height, shrink above range, a write to a register that does not exist
		write_reg(REG_IMG_WIDTH, 10'd2);
		write_reg(REG_IMG_HEIGHT, 10'd0);
		write_reg(REG_DEST_X, 10'd0);
		write_reg(REG_DEST_Y, 10'd0);
		write_reg(REG_SHRINK, 10'd31);
		write_reg(REG_UNUSED_FIRST + 3'd1, 10'h3FF);
		end_writes();
		queue_byte(8'h12, 1'b1);
		queue_byte(8'h34, 1'b0);
		queue_byte(8'h56, 1'b0);
		queue_byte(8'hAB, 1'b0);
		queue_byte(8'hCD, 1'b0);
		queue_byte(8'hEF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);

		while (random_items < RANDOM_ITEMS) begin
			wait_quiet();
			idle_on = (random_items < CALM_AFTER) && ($urandom_range(0, 3) != 0);
			big = 1'b0;
			if (wide_left && $urandom_range(0, 15) == 0) begin
				wide_left = 1'b0;
				big = 1'b1;
				write_reg(REG_IMG_WIDTH, 10'($urandom_range(800, 1023)));
				write_reg(REG_IMG_HEIGHT, 10'd1);
			end else if (tall_left && $urandom_range(0, 15) == 0) begin
				tall_left = 1'b0;
				big = 1'b1;
				write_reg(REG_IMG_WIDTH, 10'd1);
				write_reg(REG_IMG_HEIGHT, 10'($urandom_range(400, 511)));
			end else begin
				write_reg(REG_IMG_WIDTH, reg_value(REG_IMG_WIDTH));
				write_reg(REG_IMG_HEIGHT, reg_value(REG_IMG_HEIGHT));
			end
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_DEST_X, reg_value(REG_DEST_X));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_DEST_Y, reg_value(REG_DEST_Y));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_SHRINK, reg_value(REG_SHRINK));
			if ($urandom_range(0, 7) == 0) begin
				idx = 3'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST));
				write_reg(idx, reg_value(idx));
			end
			end_writes();
			w = (img_w == 0) ? 1 : img_w;
			h = (img_h == 0) ? 1 : img_h;
			n = image_bytes(w, h);
			shape = $urandom_range(0, 9);
			if (big) begin
				// leading part only of an oversized image
				random_items += push_image(w, h, BIG_BYTES);
			end else if (shape == 0) begin
				// noise with stray restarts
				k = $urandom_range(10, 60);
				for (int unsigned j = 0; j < k; j++)
					queue_byte(8'($urandom), $urandom_range(0, 15) == 0);
				random_items += k;
			end else if (shape == 1) begin
				// cut an image short and restart
				random_items += push_image(w, h, $urandom_range(1, n));
				random_items += push_image(w, h, n);
			end else if (shape == 2) begin
				// change one register part way through an image
				k = push_image(w, h, $urandom_range(1, n));
				random_items += k;
				wait_quiet();
				idx = 3'($urandom_range(REG_IMG_WIDTH, REG_SHRINK));
				write_reg(idx, reg_value(idx));
				end_writes();
				w = (img_w == 0) ? 1 : img_w;
				h = (img_h == 0) ? 1 : img_h;
				n = image_bytes(w, h);
				n = (n > k) ? n - k : $urandom_range(1, 8);
				for (int unsigned j = 0; j < n; j++)
					queue_byte(8'($urandom), 1'b0);
				random_items += n;
			end else begin
				reps = $urandom_range(1, 3);
				for (int unsigned j = 0; j < reps; j++)
					random_items += push_image(w, h, n);
				// trailing bytes past the last row are ignored
				if ($urandom_range(0, 3) == 0) begin
					k = $urandom_range(1, 5);
					for (int unsigned j = 0; j < k; j++)
						queue_byte(8'($urandom), 1'b0);
				end
			end
		end

		idle_on = 1'b0;
		wait_quiet();
		if (mismatches == 0 && expected_writes.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bmpb_pkg.sv
hdl/bmpb_unpack.sv
hdl/bmpb_place.sv
hdl/bmp_row_to_framebuffer_blit.sv
bench/bmp_row_to_framebuffer_blit_tb.sv
